// File: rtl/heap_sort_engine_assert.svh
// ----------------------------------------------------------------------------
// Heap sort engine assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define HSE_ASSERT_ALW(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (cond)) else $error(msg);
`define HSE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) else $error(msg);
`else
`define HSE_ASSERT_ALW(lbl, clk, rst, cond, msg)
`define HSE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// Heap sort engine package
// Payload structs, configuration struct and register map constants.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int KEY_IO_W = 32;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_SORT_DESC   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_KEYS_SIGNED = 1'b1;

  typedef struct packed {
    logic [KEY_IO_W-1:0] key_in;
    logic                is_last;
  } in_item_t;

  typedef struct packed {
    logic [KEY_IO_W-1:0] key_out;
    logic                last_out;
    logic                overflow;
  } out_item_t;

  typedef struct packed {
    logic sort_descending;
    logic keys_signed;
  } cfg_t;

endpackage

// File: rtl/hse_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hse_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/hse_regs.sv
// ----------------------------------------------------------------------------
// Heap sort engine configuration registers
// APB-style register file holding sort direction and key signedness.
// ----------------------------------------------------------------------------
module hse_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hse_pkg::PADDR_W-1:0] paddr,
  input  logic [hse_pkg::PDATA_W-1:0] pwdata,
  output logic [hse_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output hse_pkg::cfg_t               cfg
);

  logic                          sort_desc_r;
  logic                          keys_signed_r;
  logic                          wr_en;
  logic [hse_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[hse_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_desc_r   <= 1'b0;
      keys_signed_r <= 1'b0;
    end else if (wr_en) begin
      if (reg_idx == hse_pkg::REG_SORT_DESC) begin
        sort_desc_r <= pwdata[0];
      end
      if (reg_idx == hse_pkg::REG_KEYS_SIGNED) begin
        keys_signed_r <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      hse_pkg::REG_SORT_DESC:   prdata[0] = sort_desc_r;
      hse_pkg::REG_KEYS_SIGNED: prdata[0] = keys_signed_r;
      default:                  prdata    = '0;
    endcase
  end

  assign cfg.sort_descending = sort_desc_r;
  assign cfg.keys_signed     = keys_signed_r;

endmodule

// File: rtl/hse_sorter.sv
// ----------------------------------------------------------------------------
// Heap sort engine sequencer
// Loads keys into the key RAM, runs heap build and pops by sift-down,
// then reads the sorted store out one key per cycle.
// ----------------------------------------------------------------------------
`include "heap_sort_engine_assert.svh"

module hse_sorter #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hse_pkg::in_item_t  in_item,
  input  hse_pkg::cfg_t      cfg,
  output logic               out_valid,
  output hse_pkg::out_item_t out_item
);

  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int CH_W   = ADDR_W + 2;

  typedef enum logic [9:0] {
    ST_LOAD     = 10'b0000000001,
    ST_BUILD_RD = 10'b0000000010,
    ST_HELD     = 10'b0000000100,
    ST_SWAP_RD0 = 10'b0000001000,
    ST_SWAP_RD1 = 10'b0000010000,
    ST_SWAP_WR  = 10'b0000100000,
    ST_SD_L     = 10'b0001000000,
    ST_SD_R     = 10'b0010000000,
    ST_SD_CMP   = 10'b0100000000,
    ST_EMIT     = 10'b1000000000
  } state_t;

  function automatic logic [KEY_WIDTH-1:0] ord_f(input logic [KEY_WIDTH-1:0] k,
                                                 input logic sgn, input logic desc);
    logic [KEY_WIDTH-1:0] v;
    v = k;
    if (sgn) begin
      v[KEY_WIDTH-1] = ~v[KEY_WIDTH-1];
    end
    if (desc) begin
      v = ~v;
    end
    return v;
  endfunction

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovf_seen_r, ovf_seen_nxt;
  logic                 ovf_run_r, ovf_run_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     size_r, size_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  logic [KEY_WIDTH-1:0] held_r, held_nxt;
  logic [KEY_WIDTH-1:0] best_r, best_nxt;
  logic [ADDR_W-1:0]    best_idx_r, best_idx_nxt;
  logic                 has_right_r, has_right_nxt;
  logic                 build_r, build_nxt;
  logic                 desc_r, desc_nxt;
  logic                 sgn_r, sgn_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  logic [CH_W-1:0]      child_w;
  logic [CH_W-1:0]      size_ext;
  logic                 full_w;
  logic [CNT_W-1:0]     n_tmp;
  logic [KEY_WIDTH-1:0] cand_w;
  logic [ADDR_W-1:0]    cand_idx_w;
  logic                 sift_done;

  hse_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(MAX_ITEMS)
  ) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign child_w  = (CH_W'(pos_r) << 1) | CH_W'(1);
  assign size_ext = CH_W'(size_r);
  assign full_w   = (count_r == CNT_W'(MAX_ITEMS));
  assign busy     = (state_r != ST_LOAD);

  always_comb begin
    if (has_right_r && (ord_f(best_r, sgn_r, desc_r) < ord_f(ram_rdata, sgn_r, desc_r))) begin
      cand_w     = ram_rdata;
      cand_idx_w = best_idx_r + ADDR_W'(1);
    end else begin
      cand_w     = best_r;
      cand_idx_w = best_idx_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_seen_nxt  = ovf_seen_r;
    ovf_run_nxt   = ovf_run_r;
    n_nxt         = n_r;
    size_nxt      = size_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    held_nxt      = held_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    has_right_nxt = has_right_r;
    build_nxt     = build_r;
    desc_nxt      = desc_r;
    sgn_nxt       = sgn_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = held_r;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;
    sift_done     = 1'b0;
    n_tmp         = count_r;

    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          if (!full_w) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(count_r);
            ram_wdata = KEY_WIDTH'(in_item.key_in);
            n_tmp     = count_r + CNT_W'(1);
          end
          if (in_item.is_last) begin
            n_nxt        = n_tmp;
            count_nxt    = '0;
            ovf_seen_nxt = 1'b0;
            ovf_run_nxt  = ovf_seen_r || full_w;
            desc_nxt     = cfg.sort_descending;
            sgn_nxt      = cfg.keys_signed;
            if (n_tmp >= CNT_W'(2)) begin
              idx_nxt   = ADDR_W'((n_tmp >> 1) - CNT_W'(1));
              size_nxt  = n_tmp;
              build_nxt = 1'b1;
              state_nxt = ST_BUILD_RD;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_EMIT;
            end
          end else begin
            count_nxt    = n_tmp;
            ovf_seen_nxt = ovf_seen_r || full_w;
          end
        end
      end
      ST_BUILD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = ST_HELD;
      end
      ST_HELD: begin
        held_nxt  = ram_rdata;
        pos_nxt   = idx_r;
        state_nxt = ST_SD_L;
      end
      ST_SWAP_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = ST_SWAP_RD1;
      end
      ST_SWAP_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        held_nxt  = ram_rdata;
        state_nxt = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        pos_nxt   = '0;
        size_nxt  = CNT_W'(idx_r);
        state_nxt = ST_SD_L;
      end
      ST_SD_L: begin
        if (child_w < size_ext) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(child_w);
          state_nxt = ST_SD_R;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = held_r;
          sift_done = 1'b1;
        end
      end
      ST_SD_R: begin
        best_nxt     = ram_rdata;
        best_idx_nxt = ADDR_W'(child_w);
        if ((child_w + CH_W'(1)) < size_ext) begin
          ram_re        = 1'b1;
          ram_raddr     = ADDR_W'(child_w + CH_W'(1));
          has_right_nxt = 1'b1;
        end else begin
          has_right_nxt = 1'b0;
        end
        state_nxt = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        ram_we = 1'b1;
        ram_waddr = pos_r;
        if (ord_f(held_r, sgn_r, desc_r) >= ord_f(cand_w, sgn_r, desc_r)) begin
          ram_wdata = held_r;
          sift_done = 1'b1;
        end else begin
          ram_wdata = cand_w;
          pos_nxt   = cand_idx_w;
          state_nxt = ST_SD_L;
        end
      end
      ST_EMIT: begin
        ram_re        = 1'b1;
        ram_raddr     = idx_r;
        out_valid_nxt = 1'b1;
        out_last_nxt  = ((CNT_W'(idx_r) + CNT_W'(1)) == n_r);
        if (out_last_nxt) begin
          state_nxt = ST_LOAD;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (sift_done) begin
      if (build_r) begin
        if (idx_r == '0) begin
          build_nxt = 1'b0;
          idx_nxt   = ADDR_W'(n_r - CNT_W'(1));
          state_nxt = ST_SWAP_RD0;
        end else begin
          idx_nxt   = idx_r - ADDR_W'(1);
          state_nxt = ST_BUILD_RD;
        end
      end else begin
        if (idx_r == ADDR_W'(1)) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt   = idx_r - ADDR_W'(1);
          state_nxt = ST_SWAP_RD0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_seen_r  <= 1'b0;
      ovf_run_r   <= 1'b0;
      build_r     <= 1'b0;
      desc_r      <= 1'b0;
      sgn_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      has_right_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      ovf_run_r   <= ovf_run_nxt;
      build_r     <= build_nxt;
      desc_r      <= desc_nxt;
      sgn_r       <= sgn_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      has_right_r <= has_right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    size_r     <= size_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    held_r     <= held_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_item.key_out  = hse_pkg::KEY_IO_W'(ram_rdata);
  assign out_item.last_out = out_last_r;
  assign out_item.overflow = ovf_run_r;

  `HSE_ASSERT_IMP(a_no_rw_collide, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "key RAM read and write hit the same entry")
  `HSE_ASSERT_IMP(a_child_in_heap, clk, rst_n, ram_re && (state_r == ST_SD_L), CH_W'(ram_raddr) < size_ext, "sift read outside heap")
  `HSE_ASSERT_ALW(a_count_bound, clk, rst_n, count_r <= CNT_W'(MAX_ITEMS), "item count beyond capacity")
  `HSE_ASSERT_IMP(a_idle_after_last, clk, rst_n, out_valid_r && out_last_r, !busy && (count_r == '0), "engine not idle after final transfer")

endmodule

// File: rtl/heap_sort_engine.sv
// Load: one cycle per key, start is taken in any cycle while busy is low.
// Sort: each sift-down level reads the left child, then the right child, then compares; build
// and pop add setup steps, and the single read port of the key RAM bounds the sort rate.
// Emit: one key per cycle from the first result, out_valid strobes for one cycle each.
// The receiver cannot stall; the next set is accepted in the cycle of the last result.
// Sync reset (rst_n low) clears count, overflow flags and control registers; datapath and store stay.
// ----------------------------------------------------------------------------
// Heap sort engine
// Heapsort of up to MAX_ITEMS keys with an APB-style configuration port.
// ----------------------------------------------------------------------------
module heap_sort_engine #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  hse_pkg::in_item_t           in_item,
  output logic                        out_valid,
  output hse_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hse_pkg::PADDR_W-1:0] paddr,
  input  logic [hse_pkg::PDATA_W-1:0] pwdata,
  output logic [hse_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  hse_pkg::cfg_t cfg;

  hse_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  hse_sorter #(
    .MAX_ITEMS(MAX_ITEMS),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_sorter (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .cfg      (cfg),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

// File: verif/heap_sort_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heap sort engine testbench
// Loads sets of keys through the start/busy port and predicts each sorted
// run from its own copy of the loaded set and the order registers. It checks
// every strobed result in order, and it covers dropped keys on a full store
// and all four register settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STORE_DEPTH  = 64;
  localparam int STALL_LIMIT  = 20000;
  localparam int TARGET_KEYS  = 470;
  localparam int SETTLE_TICKS = 20;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  hse_pkg::in_item_t           in_item;
  logic                        out_valid;
  hse_pkg::out_item_t          out_item;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [hse_pkg::PADDR_W-1:0] paddr;
  logic [hse_pkg::PDATA_W-1:0] pwdata;
  logic [hse_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  logic [31:0]        loaded_keys [$];
  logic               keys_dropped;
  logic               order_desc;
  logic               order_signed;
  hse_pkg::out_item_t sorted_run_q [$];
  hse_pkg::out_item_t want;
  int                 mismatch_count;
  int                 keys_sent;
  int                 gap_pct;
  int                 quiet_cycles;

  heap_sort_engine DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] rank_of(logic [31:0] k);
    logic [31:0] r;
    r = k;
    if (order_signed) r[31] = ~r[31];
    if (order_desc) r = ~r;
    return r;
  endfunction

  function automatic void predict_sorted_run();
    logic [31:0]        keys [$];
    logic [31:0]        k;
    int                 j;
    hse_pkg::out_item_t r;
    keys = loaded_keys;
    for (int i = 1; i < keys.size(); i++) begin
      k = keys[i];
      j = i - 1;
      while (j >= 0 && rank_of(keys[j]) > rank_of(k)) begin
        keys[j + 1] = keys[j];
        j--;
      end
      keys[j + 1] = k;
    end
    for (int i = 0; i < keys.size(); i++) begin
      r.key_out  = keys[i];
      r.last_out = (i == keys.size() - 1);
      r.overflow = keys_dropped;
      sorted_run_q.push_back(r);
    end
    loaded_keys.delete();
    keys_dropped = 1'b0;
  endfunction

  function automatic void load_key(logic [31:0] k, logic last);
    if (loaded_keys.size() < STORE_DEPTH) begin
      loaded_keys.push_back(k);
    end else begin
      keys_dropped = 1'b1;
    end
    if (last) predict_sorted_run();
  endfunction

  function automatic logic [31:0] rand_key();
    logic [31:0] k;
    case ($urandom_range(3))
      0: k = $urandom();
      1: k = $urandom_range(7);
      2: k = 32'h8000_0000 + $urandom_range(7) - 32'd4;
      default: k = ~$urandom_range(7);
    endcase
    return k;
  endfunction

  // hold start high across back-to-back transfers, dropping it only for random gaps set by gap_pct
  task automatic send_key(input logic [31:0] k, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= {k, last};
    do @(posedge clk); while (busy);
    keys_sent++;
    load_key(k, last);
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_key(rand_key(), i == n - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sorted_run_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hse_pkg::REG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'b0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== val) begin
      $display("%0t readback reg %0d: expected %b actual %b", $time, idx, val, prdata[0]);
      mismatch_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_order(input logic desc, input logic sgn);
    drain();
    write_reg(hse_pkg::REG_SORT_DESC, desc);
    write_reg(hse_pkg::REG_KEYS_SIGNED, sgn);
    order_desc   = desc;
    order_signed = sgn;
  endtask

  task automatic send_extremes();
    send_key(32'hFFFF_FFFF, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h7FFF_FFFF, 1'b0);
    send_key(32'h8000_0000, 1'b1);
  endtask

  task automatic test_directed();
    gap_pct = 28;
    set_order(1'b0, 1'b0);
    send_extremes();
    send_key(32'h0000_0001, 1'b0);
    send_key(32'h0000_0001, 1'b1);
    send_key(32'hA5A5_A5A5, 1'b1);
    set_order(1'b1, 1'b0);
    send_extremes();
    set_order(1'b0, 1'b1);
    send_extremes();
    set_order(1'b1, 1'b1);
    send_extremes();
  endtask

  task automatic test_store_full();
    gap_pct = 28;
    set_order(1'($urandom_range(1)), 1'($urandom_range(1)));
    send_set(STORE_DEPTH);
    send_set(STORE_DEPTH + 1);
    send_set(STORE_DEPTH + 3);
  endtask

  task automatic test_back_to_back();
    gap_pct = 0;
    set_order(1'b0, 1'b1);
    repeat (5) send_set($urandom_range(1, 12));
    send_set(STORE_DEPTH);
  endtask

  task automatic test_random_sets();
    int n;
    gap_pct = 28;
    while (keys_sent < TARGET_KEYS) begin
      set_order(1'($urandom_range(1)), 1'($urandom_range(1)));
      repeat ($urandom_range(2, 5)) begin
        n = ($urandom_range(99) < 88) ? $urandom_range(1, 12) : $urandom_range(13, 64);
        send_set(n);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (sorted_run_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h/%b/%b", $time,
                 out_item.key_out, out_item.last_out, out_item.overflow);
        mismatch_count++;
      end else begin
        want = sorted_run_q.pop_front();
        if (out_item.key_out !== want.key_out) begin
          $display("%0t key_out: expected %h actual %h", $time, want.key_out,
                   out_item.key_out);
          mismatch_count++;
        end
        if (out_item.last_out !== want.last_out) begin
          $display("%0t last_out: expected %b actual %b", $time, want.last_out,
                   out_item.last_out);
          mismatch_count++;
        end
        if (out_item.overflow !== want.overflow) begin
          $display("%0t overflow: expected %b actual %b", $time, want.overflow,
                   out_item.overflow);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_item        <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    keys_dropped   = 1'b0;
    order_desc     = 1'b0;
    order_signed   = 1'b0;
    mismatch_count = 0;
    keys_sent      = 0;
    gap_pct        = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_store_full();
    test_back_to_back();
    test_random_sets();
    drain();

    if (sorted_run_q.size() != 0) begin
      $display("%0t results missing: expected %0d more actual 0", $time, sorted_run_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_ram.sv
rtl/hse_regs.sv
rtl/hse_sorter.sv
rtl/heap_sort_engine.sv
verif/heap_sort_engine_tb.sv
